[rtl/crcpr_pkg.sv]
// Package for the CRC packet receiver: word structs, codes, operation type
// and the CRC-8 byte update. No dependencies.
package crcpr_pkg;

   localparam int DATA_LEN_DEF   = 16;
   localparam int RING_SLOTS_DEF = 8;
   localparam int RADDR_W        = 13;   // holds any ring address in range
   localparam int IDX_W          = 6;    // holds any packet byte index in range
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [1:0] CMD_LINE = 2'd0;
   localparam logic [1:0] CMD_APP  = 2'd1;
   localparam logic [1:0] CMD_POP  = 2'd2;

   localparam logic [1:0] KIND_LINE   = 2'd0;
   localparam logic [1:0] KIND_POP    = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] CSR_POLY = 2'd0;
   localparam logic [1:0] CSR_INIT = 2'd1;
   localparam logic [1:0] CSR_ACK  = 2'd2;
   localparam logic [1:0] CSR_RETX = 2'd3;

   localparam logic [7:0] FILL_BYTE = 8'hff;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] byte_in;
   } crcpr_req_type;

   typedef struct packed {
      logic [1:0] out_kind;
      logic [7:0] out_byte;
      logic       out_last;
      logic       packets_waiting;
      logic       overflow;
   } crcpr_rsp_type;

   typedef struct packed {
      logic [7:0] poly;
      logic [7:0] init;
      logic [7:0] ack;
      logic [7:0] retx;
   } crcpr_csr_type;

   typedef enum logic [1:0] {RX_LEN, RX_DATA, RX_CRC} crcpr_rx_type;

   typedef enum logic [2:0] {
      OP_RING_WR, OP_APP, OP_SINGLE, OP_RESEND, OP_STATUS, OP_POP
   } crcpr_opc_type;

   typedef enum logic [1:0] {BK_IDLE, BK_BURST} crcpr_bk_type;

   typedef logic [RADDR_W-1:0] crcpr_raddr_type;
   typedef logic [IDX_W-1:0]   crcpr_idx_type;

   typedef struct packed {
      crcpr_opc_type   opc;
      logic [7:0]      data;
      crcpr_idx_type   idx;
      crcpr_raddr_type addr;
      logic            last;
      logic            pkts_waiting;
      logic            overflow;
   } crcpr_op_type;

   function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b,
                                           logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) c = {c[6:0], 1'b0} ^ poly;
         else c = {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[rtl/crcpr_front.sv]
// Front end: receive state, CRC check, ring pointers and flags; turns each
// word into at most one back-end operation. Depends on crcpr_pkg.
module crcpr_front import crcpr_pkg::*; #(
   parameter int DATA_LEN   = DATA_LEN_DEF,
   parameter int RING_SLOTS = RING_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  crcpr_csr_type csr,
   input  logic          accept,
   input  crcpr_req_type req,
   output logic          push,
   output crcpr_op_type  op
);
   localparam int SLOT_BYTES = DATA_LEN + 1;
   localparam int PKT_BYTES  = DATA_LEN + 2;
   localparam int RAW = $clog2(RING_SLOTS * SLOT_BYTES);
   localparam int SW  = $clog2(RING_SLOTS);
   localparam int CW  = (DATA_LEN > 1) ? $clog2(DATA_LEN) : 1;
   localparam int AW  = $clog2(PKT_BYTES);

   crcpr_rx_type   phase_ff, phase_in;
   logic [CW-1:0]  cnt_ff, cnt_in, k;
   logic [7:0]     crc_ff, crc_in;
   logic           ackm_ff, ackm_in, retxm_ff, retxm_in;
   logic [SW-1:0]  wr_ff, wr_in, rd_ff, rd_in, wr_nx, rd_nx;
   logic [RAW-1:0] wrb_ff, wrb_in, rdb_ff, rdb_in, wrb_nx, rdb_nx;
   logic [AW-1:0]  app_ff, app_in, aidx;
   logic           ovf_ff, ovf_in;

   always_comb begin
      wr_nx  = (wr_ff == SW'(RING_SLOTS - 1)) ? '0 : wr_ff + SW'(1);
      rd_nx  = (rd_ff == SW'(RING_SLOTS - 1)) ? '0 : rd_ff + SW'(1);
      wrb_nx = (wr_ff == SW'(RING_SLOTS - 1)) ? '0 : wrb_ff + RAW'(SLOT_BYTES);
      rdb_nx = (rd_ff == SW'(RING_SLOTS - 1)) ? '0 : rdb_ff + RAW'(SLOT_BYTES);
      k      = (cnt_ff >= CW'(DATA_LEN - 1)) ? CW'(DATA_LEN - 1) : cnt_ff;
      aidx   = (app_ff >= AW'(PKT_BYTES - 1)) ? AW'(PKT_BYTES - 1) : app_ff;
      if (app_ff > AW'(PKT_BYTES - 1)) aidx = '0;
   end

   always_comb begin
      phase_in = phase_ff; cnt_in = cnt_ff; crc_in = crc_ff;
      ackm_in = ackm_ff; retxm_in = retxm_ff;
      wr_in = wr_ff; rd_in = rd_ff; wrb_in = wrb_ff; rdb_in = rdb_ff;
      app_in = app_ff; ovf_in = ovf_ff;
      push = 1'b0;
      op = '0;
      op.opc = OP_RING_WR;
      case (req.cmd)
         CMD_LINE: begin
            unique case (phase_ff)
               RX_LEN: begin
                  push = 1'b1;
                  op.addr = crcpr_raddr_type'(wrb_ff);
                  op.data = req.byte_in;
                  crc_in = crc_byte(csr.init, req.byte_in, csr.poly);
                  ackm_in = (req.byte_in == 8'd1);
                  retxm_in = (req.byte_in == 8'd1);
                  cnt_in = '0;
                  phase_in = RX_DATA;
               end
               RX_DATA: begin
                  push = 1'b1;
                  op.addr = crcpr_raddr_type'(wrb_ff + RAW'(1) + RAW'(k));
                  op.data = req.byte_in;
                  crc_in = crc_byte(crc_ff, req.byte_in, csr.poly);
                  if (k == '0) begin
                     if (req.byte_in != csr.ack) ackm_in = 1'b0;
                     if (req.byte_in != csr.retx) retxm_in = 1'b0;
                  end else if (req.byte_in != FILL_BYTE) begin
                     ackm_in = 1'b0;
                     retxm_in = 1'b0;
                  end
                  if (k == CW'(DATA_LEN - 1)) begin
                     cnt_in = '0;
                     phase_in = RX_CRC;
                  end else begin
                     cnt_in = k + CW'(1);
                  end
               end
               RX_CRC: begin
                  phase_in = RX_LEN;
                  cnt_in = '0;
                  if (req.byte_in != crc_ff) begin
                     push = 1'b1;
                     op.opc = OP_SINGLE;
                     op.data = csr.retx;
                     app_in = '0;
                  end else if (retxm_ff) begin
                     push = 1'b1;
                     op.opc = OP_RESEND;
                     app_in = '0;
                  end else if (ackm_ff) begin
                     push = 1'b0;   // ACK absorbed
                  end else if (wr_nx == rd_ff) begin
                     push = 1'b1;
                     op.opc = OP_STATUS;
                     ovf_in = 1'b1;
                  end else begin
                     push = 1'b1;
                     op.opc = OP_SINGLE;
                     op.data = csr.ack;
                     wr_in = wr_nx;
                     wrb_in = wrb_nx;
                     app_in = '0;
                  end
               end
               default: phase_in = RX_LEN;
            endcase
         end
         CMD_APP: begin
            push = 1'b1;
            op.opc = OP_APP;
            op.data = req.byte_in;
            op.idx = crcpr_idx_type'(aidx);
            op.last = (aidx == AW'(PKT_BYTES - 1));
            app_in = (aidx == AW'(PKT_BYTES - 1)) ? '0 : aidx + AW'(1);
         end
         CMD_POP: begin
            push = 1'b1;
            if (rd_ff == wr_ff) begin
               op.opc = OP_STATUS;
            end else begin
               op.opc = OP_POP;
               op.addr = crcpr_raddr_type'(rdb_ff);
               rd_in = rd_nx;
               rdb_in = rdb_nx;
            end
         end
         default: push = 1'b0;
      endcase
      op.pkts_waiting = (rd_in != wr_in);
      op.overflow = ovf_in;
      push = push & accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= RX_LEN;
         cnt_ff <= '0;
         crc_ff <= csr.init;
         ackm_ff <= 1'b1;
         retxm_ff <= 1'b1;
         wr_ff <= '0; rd_ff <= '0; wrb_ff <= '0; rdb_ff <= '0;
         app_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         cnt_ff <= cnt_in;
         crc_ff <= crc_in;
         ackm_ff <= ackm_in;
         retxm_ff <= retxm_in;
         wr_ff <= wr_in; rd_ff <= rd_in; wrb_ff <= wrb_in; rdb_ff <= rdb_in;
         app_ff <= app_in;
         ovf_ff <= ovf_in;
      end
   end
endmodule

[rtl/crcpr_queue.sv]
// Short operation queue between front and back end.
// Depends on crcpr_pkg.
module crcpr_queue import crcpr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  crcpr_op_type push_op,
   output logic         full,
   input  logic         pop,
   output logic         nonempty,
   output crcpr_op_type head
);
   localparam int PW = $clog2(QUEUE_DEPTH);

   crcpr_op_type  mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wp_ff, rp_ff;
   logic [PW:0]   cnt_ff, cnt_in;

   assign full = (cnt_ff == (PW+1)'(QUEUE_DEPTH));
   assign nonempty = (cnt_ff != '0);
   assign head = mem_ff[rp_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + (PW+1)'(1);
      else if (pop && !push) cnt_in = cnt_ff - (PW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_op;
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + PW'(1);
         if (pop) rp_ff <= rp_ff + PW'(1);
         cnt_ff <= cnt_in;
      end
   end
endmodule

[rtl/crcpr_back.sv]
// Back end: ring memory, last-sent buffer, burst sequencer and result
// register. Depends on crcpr_pkg.
module crcpr_back import crcpr_pkg::*; #(
   parameter int DATA_LEN   = DATA_LEN_DEF,
   parameter int RING_SLOTS = RING_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  crcpr_csr_type csr,
   input  logic          q_nonempty,
   input  crcpr_op_type  q_head,
   output logic          q_pop,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output crcpr_rsp_type rsp_data
);
   localparam int SLOT_BYTES = DATA_LEN + 1;
   localparam int PKT_BYTES  = DATA_LEN + 2;
   localparam int DEPTH = RING_SLOTS * SLOT_BYTES;
   localparam int RAW = $clog2(DEPTH);
   localparam int AW  = $clog2(PKT_BYTES);

   logic [7:0]     ring_mem [DEPTH];
   logic [7:0]     rd_data_ff;
   logic           rd_en, wr_en;
   logic [RAW-1:0] rd_addr, wr_addr;

   logic [7:0]     last_ff [PKT_BYTES];
   logic           ls_we;
   logic [AW-1:0]  ls_addr;
   logic [7:0]     ls_data;

   crcpr_bk_type   st_ff, st_in;
   crcpr_op_type   cur_ff, cur_in;
   logic [AW-1:0]  cnt_ff, cnt_in;
   logic [7:0]     crc_ff, crc_in;
   logic [RAW-1:0] addr_ff, addr_in;

   logic           rv_ff, rv_in;
   crcpr_rsp_type  rsp_ff, rsp_in;
   logic           can_emit;
   logic [7:0]     b;
   logic           endb;

   assign can_emit = !rv_ff || rsp_ready;
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      st_in = st_ff; cur_in = cur_ff; cnt_in = cnt_ff; crc_in = crc_ff;
      addr_in = addr_ff;
      rv_in = rv_ff && !rsp_ready;
      rsp_in = rsp_ff;
      q_pop = 1'b0;
      rd_en = 1'b0; rd_addr = addr_ff;
      wr_en = 1'b0; wr_addr = q_head.addr[RAW-1:0];
      ls_we = 1'b0; ls_addr = cnt_ff; ls_data = q_head.data;
      b = 8'h00;
      endb = 1'b0;
      unique case (st_ff)
         BK_IDLE: begin
            if (q_nonempty) begin
               case (q_head.opc)
                  OP_RING_WR: begin
                     wr_en = 1'b1;
                     q_pop = 1'b1;
                  end
                  OP_APP, OP_STATUS: begin
                     if (can_emit) begin
                        q_pop = 1'b1;
                        rv_in = 1'b1;
                        rsp_in.packets_waiting = q_head.pkts_waiting;
                        rsp_in.overflow = q_head.overflow;
                        if (q_head.opc == OP_APP) begin
                           ls_we = 1'b1;
                           ls_addr = q_head.idx[AW-1:0];
                           rsp_in.out_kind = KIND_LINE;
                           rsp_in.out_byte = q_head.data;
                           rsp_in.out_last = q_head.last;
                        end else begin
                           rsp_in.out_kind = KIND_STATUS;
                           rsp_in.out_byte = 8'h00;
                           rsp_in.out_last = 1'b1;
                        end
                     end
                  end
                  default: begin
                     // bursts: single, resend, pop (pop primes first read)
                     q_pop = 1'b1;
                     cur_in = q_head;
                     cnt_in = '0;
                     crc_in = csr.init;
                     addr_in = q_head.addr[RAW-1:0];
                     rd_addr = q_head.addr[RAW-1:0];
                     rd_en = (q_head.opc == OP_POP);
                     st_in = BK_BURST;
                  end
               endcase
            end
         end
         BK_BURST: begin
            if (cur_ff.opc == OP_POP) begin
               b = rd_data_ff;
               endb = (cnt_ff == AW'(SLOT_BYTES - 1));
            end else if (cur_ff.opc == OP_RESEND) begin
               b = last_ff[cnt_ff];
               endb = (cnt_ff == AW'(PKT_BYTES - 1));
            end else begin
               if (cnt_ff == '0) b = 8'd1;
               else if (cnt_ff == AW'(1)) b = cur_ff.data;
               else if (cnt_ff == AW'(PKT_BYTES - 1)) b = crc_ff;
               else b = FILL_BYTE;
               endb = (cnt_ff == AW'(PKT_BYTES - 1));
            end
            if (can_emit) begin
               rv_in = 1'b1;
               rsp_in.out_kind = (cur_ff.opc == OP_POP) ? KIND_POP : KIND_LINE;
               rsp_in.out_byte = b;
               rsp_in.out_last = endb;
               rsp_in.packets_waiting = cur_ff.pkts_waiting;
               rsp_in.overflow = cur_ff.overflow;
               if (cur_ff.opc == OP_SINGLE) begin
                  ls_we = 1'b1;
                  ls_data = b;
                  crc_in = crc_byte(crc_ff, b, csr.poly);
               end
               cnt_in = cnt_ff + AW'(1);
               if (cur_ff.opc == OP_POP && !endb) begin
                  addr_in = addr_ff + RAW'(1);
                  rd_addr = addr_ff + RAW'(1);
                  rd_en = 1'b1;
               end
               if (endb) st_in = BK_IDLE;
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= q_head.data;
      if (rd_en) rd_data_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PKT_BYTES; i++) last_ff[i] <= 8'h00;
      end else if (ls_we) begin
         last_ff[ls_addr] <= ls_data;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      cnt_ff <= cnt_in;
      crc_ff <= crc_in;
      addr_ff <= addr_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         st_ff <= BK_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
   end
endmodule

[rtl/crc_packet_receiver_with_ack_retx.sv]
// Top level of the CRC packet receiver with ACK and retransmit handling.
// Holds the CSR bank and ties front end, op queue and back end together.
// Depends on crcpr_pkg, crcpr_front, crcpr_queue, crcpr_back.
//
//  channel | ports                        | carries
//  --------+------------------------------+---------------------------------
//  req     | req_valid req_ready req_data | cmd + byte word, one per handshake
//  rsp     | rsp_valid rsp_ready rsp_data | result word (kind/byte/last/flags)
//  csr     | csr_valid csr_ready csr_*    | register index + write data
//
// Cycles: the front takes one req word per cycle while the 4-entry op queue
//    has room; a line byte is one ring write and an app byte one rsp word.
// A packet's CRC byte, or a pop while the ring holds a packet, may start a
//    burst: a dispatch step, then DATA_LEN+2 rsp words to the line or
//    DATA_LEN+1 on pop, one per cycle unless rsp stalls. Burst length sets
//    sustained rate; the back end takes no other op during a burst.
// Reset is synchronous; it clears pointers, flags and the last-sent buffer.
// rsp stalls hold the back end only; the front keeps filling the queue.
module crc_packet_receiver_with_ack_retx import crcpr_pkg::*; #(
   parameter int DATA_LEN   = DATA_LEN_DEF,
   parameter int RING_SLOTS = RING_SLOTS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  crcpr_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output crcpr_rsp_type rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [1:0]    csr_index,
   input  logic [7:0]    csr_wdata
);
   crcpr_csr_type csr_ff;
   logic          q_full, q_nonempty, q_push, q_pop, req_accept;
   crcpr_op_type  f_op, q_head;

   // register writes are always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.poly <= 8'h07;
         csr_ff.init <= 8'h00;
         csr_ff.ack  <= 8'd21;
         csr_ff.retx <= 8'd25;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_POLY: csr_ff.poly <= csr_wdata;
            CSR_INIT: csr_ff.init <= csr_wdata;
            CSR_ACK:  csr_ff.ack  <= csr_wdata;
            CSR_RETX: csr_ff.retx <= csr_wdata;
            default:  csr_ff.poly <= csr_ff.poly;
         endcase
      end
   end

   // front accepts whenever the queue can take an op
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   crcpr_front #(.DATA_LEN(DATA_LEN), .RING_SLOTS(RING_SLOTS)) u_front (
      .clock(clock), .reset(reset), .csr(csr_ff),
      .accept(req_accept), .req(req_data),
      .push(q_push), .op(f_op)
   );

   crcpr_queue u_queue (
      .clock(clock), .reset(reset),
      .push(q_push), .push_op(f_op), .full(q_full),
      .pop(q_pop), .nonempty(q_nonempty), .head(q_head)
   );

   crcpr_back #(.DATA_LEN(DATA_LEN), .RING_SLOTS(RING_SLOTS)) u_back (
      .clock(clock), .reset(reset), .csr(csr_ff),
      .q_nonempty(q_nonempty), .q_head(q_head), .q_pop(q_pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // status words carry no byte and always end their step
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.out_kind == KIND_STATUS
      |-> rsp_data.out_last && rsp_data.out_byte == 8'h00)
      else $error("status word malformed");

   // overflow is sticky across consecutive results
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.overflow
      |=> !rsp_valid || rsp_data.overflow)
      else $error("overflow flag cleared");

   // the queue is never pushed while full
   a_no_q_overrun: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("op queue overrun");

   // no undefined result kind
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_kind != 2'd3)
      else $error("bad result kind");
endmodule
